>>> sv/jtok_pkg.sv
package jtok_pkg;

  localparam int MAX_DEPTH_DEF   = 16;
  localparam int POS_BITS_DEF    = 24;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_NUL      = 8'h00;

  localparam logic [1:0] TT_OBJECT    = 2'd0;
  localparam logic [1:0] TT_ARRAY     = 2'd1;
  localparam logic [1:0] TT_STRING    = 2'd2;
  localparam logic [1:0] TT_PRIMITIVE = 2'd3;

  typedef enum logic [2:0] {
    ST_TOKEN     = 3'd0,
    ST_DONE      = 3'd1,
    ST_UNCLOSED  = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_NO_OPENER = 3'd5
  } status_t;

  // byte class, as handed from front to back
  typedef struct packed {
    logic quote;
    logic lbrace;
    logic lbracket;
    logic rbrace;
    logic rbracket;
    logic bslash;
    logic ws;
    logic comma;
    logic colon;
    logic zero;
    logic fin;
  } cls_t;

endpackage

>>> sv/jtok_front.sv
module jtok_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  input  logic               final_byte,
  output logic               q_valid,
  output jtok_pkg::cls_t     q_cls,
  input  logic               q_pop
);

  localparam int QD = jtok_pkg::QUEUE_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  jtok_pkg::cls_t cls;
  jtok_pkg::cls_t q [QD];
  logic [QW-1:0]  wp;
  logic [QW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           push;

  always_comb begin
    cls.quote    = (text_byte == jtok_pkg::CH_QUOTE);
    cls.lbrace   = (text_byte == jtok_pkg::CH_LBRACE);
    cls.lbracket = (text_byte == jtok_pkg::CH_LBRACKET);
    cls.rbrace   = (text_byte == jtok_pkg::CH_RBRACE);
    cls.rbracket = (text_byte == jtok_pkg::CH_RBRACKET);
    cls.bslash   = (text_byte == jtok_pkg::CH_BSLASH);
    cls.ws       = (text_byte == jtok_pkg::CH_SPACE) || (text_byte == jtok_pkg::CH_TAB) ||
                   (text_byte == jtok_pkg::CH_CR) || (text_byte == jtok_pkg::CH_LF);
    cls.comma    = (text_byte == jtok_pkg::CH_COMMA);
    cls.colon    = (text_byte == jtok_pkg::CH_COLON);
    cls.zero     = (text_byte == jtok_pkg::CH_NUL);
    cls.fin      = final_byte;
  end

  assign in_stall = (cnt == CW'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign q_cls    = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QW'(QD - 1)) ? '0 : wp + QW'(1);
      end
      if (q_pop) begin
        rp <= (rp == QW'(QD - 1)) ? '0 : rp + QW'(1);
      end
      if (push && !q_pop) begin
        cnt <= cnt + CW'(1);
      end else if (!push && q_pop) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

>>> sv/jtok_back.sv
module jtok_back #(
  parameter int MAX_DEPTH = jtok_pkg::MAX_DEPTH_DEF,
  parameter int POS_BITS  = jtok_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  jtok_pkg::cls_t      q_cls,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          token_type,
  output logic [POS_BITS-1:0] token_number,
  output logic [POS_BITS-1:0] token_begin,
  output logic [POS_BITS-1:0] token_finish,
  output logic [POS_BITS-1:0] child_count,
  output logic [2:0]          status,
  output logic                last_result
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);

  typedef enum logic [2:0] {
    M_GAP  = 3'b001,
    M_STR  = 3'b010,
    M_PRIM = 3'b100
  } mode_t;

  typedef struct packed {
    logic                kind;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] index;
    logic [POS_BITS-1:0] children;
  } ent_t;

  typedef struct packed {
    logic [1:0]          ttype;
    logic [POS_BITS-1:0] number;
    logic [POS_BITS-1:0] first;
    logic [POS_BITS-1:0] finish;
    logic [POS_BITS-1:0] children;
    jtok_pkg::status_t   st;
    logic                last;
  } res_t;

  function automatic res_t mk(logic [1:0] tt, logic [POS_BITS-1:0] num,
                              logic [POS_BITS-1:0] b, logic [POS_BITS-1:0] f,
                              logic [POS_BITS-1:0] ch, jtok_pkg::status_t s);
    res_t r;
    r.ttype    = tt;
    r.number   = num;
    r.first    = b;
    r.finish   = f;
    r.children = ch;
    r.st       = s;
    r.last     = 1'b0;
    return r;
  endfunction

  // control state
  mode_t               mode, mode_next;
  logic                prevbs, prevbs_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [POS_BITS-1:0] pstart, pstart_next;
  logic [POS_BITS-1:0] tc, tc_next;
  logic [DW-1:0]       depth, depth_next;
  logic                err, err_next;

  // top of stack in registers, the rest in memory; below = entry under top
  ent_t                top, top_next;
  ent_t                below;
  ent_t                mem [MAX_DEPTH];
  logic                wr_en;
  ent_t                wr_data;
  logic [AW-1:0]       wa;
  logic [AW-1:0]       ra;

  // results
  res_t                cand [4];
  logic [3:0]          cv;
  res_t                slot [3];
  logic [1:0]          k;
  res_t                rbuf [3];
  logic [1:0]          rptr;
  logic [1:0]          rcnt;
  logic                out_acc;

  logic                ends;
  logic                gapbyte;
  logic                term;

  assign out_valid = (rcnt != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign q_pop     = q_valid && ((rcnt == 2'd0) || ((rcnt == 2'd1) && !out_stall));

  assign ends = q_cls.zero || q_cls.fin;
  assign term = q_cls.ws || q_cls.comma || q_cls.rbrace || q_cls.rbracket;
  assign wa   = AW'(depth - DW'(1));
  assign ra   = AW'(depth_next - DW'(2));

  always_comb begin
    mode_next   = mode;
    prevbs_next = prevbs;
    pos_next    = pos;
    pstart_next = pstart;
    tc_next     = tc;
    depth_next  = depth;
    err_next    = err;
    top_next    = top;
    wr_en       = 1'b0;
    wr_data     = top;
    gapbyte     = 1'b0;
    cv          = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (q_pop) begin
      if (err) begin
        if (ends) begin
          err_next = 1'b0;
          mode_next = M_GAP;
          prevbs_next = 1'b0;
          pos_next = '0;
          pstart_next = '0;
          tc_next = '0;
          depth_next = '0;
        end
      end else begin
        if (!q_cls.zero) begin
          case (mode)
            M_STR: begin
              if (!prevbs && q_cls.quote) begin
                cv[0]   = 1'b1;
                cand[0] = mk(jtok_pkg::TT_STRING, tc_next, pstart, pos, '0, jtok_pkg::ST_TOKEN);
                tc_next = tc_next + POS_BITS'(1);
                if (depth != '0) begin
                  top_next.children = top_next.children + POS_BITS'(1);
                end
                mode_next = M_GAP;
              end
              prevbs_next = prevbs ? 1'b0 : q_cls.bslash;
            end
            M_PRIM: begin
              if (term) begin
                cv[0]   = 1'b1;
                cand[0] = mk(jtok_pkg::TT_PRIMITIVE, tc_next, pstart, pos, '0,
                             jtok_pkg::ST_TOKEN);
                tc_next = tc_next + POS_BITS'(1);
                if (depth != '0) begin
                  top_next.children = top_next.children + POS_BITS'(1);
                end
                mode_next = M_GAP;
                gapbyte   = 1'b1;
              end
              prevbs_next = q_cls.bslash;
            end
            default: begin
              gapbyte     = 1'b1;
              prevbs_next = q_cls.bslash;
            end
          endcase

          if (gapbyte) begin
            if (q_cls.quote) begin
              mode_next   = M_STR;
              pstart_next = pos + POS_BITS'(1);
            end else if (q_cls.lbrace || q_cls.lbracket) begin
              if (depth == DW'(MAX_DEPTH)) begin
                err_next = 1'b1;
                cv[1]    = 1'b1;
                cand[1]  = mk(jtok_pkg::TT_OBJECT, '0, '0, pos, '0, jtok_pkg::ST_OVERFLOW);
              end else begin
                if (depth != '0) begin
                  top_next.children = top_next.children + POS_BITS'(1);
                  wr_en = 1'b1;
                end
                wr_data           = top_next;
                top_next.kind     = q_cls.lbracket;
                top_next.start    = pos;
                top_next.index    = tc_next;
                top_next.children = '0;
                depth_next        = depth + DW'(1);
                tc_next           = tc_next + POS_BITS'(1);
              end
            end else if (q_cls.rbrace || q_cls.rbracket) begin
              if (depth == '0) begin
                err_next = 1'b1;
                cv[1]    = 1'b1;
                cand[1]  = mk(jtok_pkg::TT_OBJECT, '0, '0, pos, '0, jtok_pkg::ST_NO_OPENER);
              end else if (top_next.kind != q_cls.rbracket) begin
                err_next = 1'b1;
                cv[1]    = 1'b1;
                cand[1]  = mk(jtok_pkg::TT_OBJECT, '0, '0, pos, '0, jtok_pkg::ST_MISMATCH);
              end else begin
                cv[1]      = 1'b1;
                cand[1]    = mk(q_cls.rbracket ? jtok_pkg::TT_ARRAY : jtok_pkg::TT_OBJECT,
                                top_next.index, top_next.start, pos, top_next.children,
                                jtok_pkg::ST_TOKEN);
                depth_next = depth - DW'(1);
                top_next   = below;
              end
            end else if (q_cls.ws || q_cls.comma || q_cls.colon) begin
              mode_next = M_GAP;
            end else begin
              mode_next   = M_PRIM;
              pstart_next = pos;
            end
          end
          pos_next = pos + POS_BITS'(1);
        end

        if (ends) begin
          if (!err_next) begin
            if (mode_next == M_STR || mode_next == M_PRIM) begin
              cv[2]   = 1'b1;
              cand[2] = mk((mode_next == M_STR) ? jtok_pkg::TT_STRING : jtok_pkg::TT_PRIMITIVE,
                           tc_next, pstart_next, pos_next, '0, jtok_pkg::ST_TOKEN);
              tc_next = tc_next + POS_BITS'(1);
            end
            cv[3]   = 1'b1;
            cand[3] = mk(jtok_pkg::TT_OBJECT, tc_next, '0, pos_next, '0,
                         (depth_next != '0) ? jtok_pkg::ST_UNCLOSED : jtok_pkg::ST_DONE);
          end
          err_next    = 1'b0;
          mode_next   = M_GAP;
          prevbs_next = 1'b0;
          pos_next    = '0;
          pstart_next = '0;
          tc_next     = '0;
          depth_next  = '0;
        end
      end
    end
  end

  // pack the candidates into consecutive slots
  always_comb begin
    k = 2'd0;
    for (int j = 0; j < 3; j++) begin
      slot[j] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (cv[i] && (k != 2'd3)) begin
        slot[k] = cand[i];
        k = k + 2'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      slot[j].last = ((2'(j) + 2'd1) == k);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    below <= (wr_en && (wa == ra)) ? wr_data : mem[ra];
    top   <= top_next;
    if (q_pop) begin
      for (int j = 0; j < 3; j++) begin
        rbuf[j] <= slot[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_GAP;
      prevbs <= 1'b0;
      pos    <= '0;
      pstart <= '0;
      tc     <= '0;
      depth  <= '0;
      err    <= 1'b0;
      rptr   <= 2'd0;
      rcnt   <= 2'd0;
    end else begin
      mode   <= mode_next;
      prevbs <= prevbs_next;
      pos    <= pos_next;
      pstart <= pstart_next;
      tc     <= tc_next;
      depth  <= depth_next;
      err    <= err_next;
      if (q_pop) begin
        rcnt <= k;
        rptr <= 2'd0;
      end else if (out_acc) begin
        rcnt <= rcnt - 2'd1;
        rptr <= rptr + 2'd1;
      end
    end
  end

  assign token_type   = rbuf[rptr].ttype;
  assign token_number = rbuf[rptr].number;
  assign token_begin  = rbuf[rptr].first;
  assign token_finish = rbuf[rptr].finish;
  assign child_count  = rbuf[rptr].children;
  assign status       = rbuf[rptr].st;
  assign last_result  = rbuf[rptr].last;

endmodule

>>> sv/json_tokenizer.sv
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | text_byte, final_byte
// output  | out_valid| out_stall | token_type, token_number, token_begin, token_finish,
//         |          |           | child_count, status, last_result
//
// One byte per cycle while each byte gives at most one result and out_stall is low;
// a byte giving n results holds the two-entry byte queue while the result
// register drains them; each result passes the byte queue and the result register.
// rst is synchronous; it clears control state, stack contents stay undefined.
// in_stall rises only when the byte queue is full; out_stall holds results and queue.
module json_tokenizer #(
  parameter int MAX_DEPTH = jtok_pkg::MAX_DEPTH_DEF,
  parameter int POS_BITS  = jtok_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          token_type,
  output logic [POS_BITS-1:0] token_number,
  output logic [POS_BITS-1:0] token_begin,
  output logic [POS_BITS-1:0] token_finish,
  output logic [POS_BITS-1:0] child_count,
  output logic [2:0]          status,
  output logic                last_result
);

  logic           q_valid;
  logic           q_pop;
  jtok_pkg::cls_t q_cls;

  jtok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .q_valid    (q_valid),
    .q_cls      (q_cls),
    .q_pop      (q_pop)
  );

  jtok_back #(
    .MAX_DEPTH (MAX_DEPTH),
    .POS_BITS  (POS_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cls        (q_cls),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_type   (token_type),
    .token_number (token_number),
    .token_begin  (token_begin),
    .token_finish (token_finish),
    .child_count  (child_count),
    .status       (status),
    .last_result  (last_result)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH_MAX = jtok_pkg::MAX_DEPTH_DEF;
  localparam int PB = jtok_pkg::POS_BITS_DEF;
  localparam int BYTE_TARGET = 385;
  localparam int HOLD_CYCLES = 120;

  typedef logic [PB-1:0] pos_t;
  typedef enum int {SCAN_IDLE, SCAN_STRING, SCAN_PRIM} scan_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;
  typedef enum int {TEXT_VALID, TEXT_DEEP, TEXT_CUT, TEXT_BROKEN, TEXT_NOISE} text_kind_t;

  typedef struct {
    logic [1:0] kind;
    pos_t num;
    pos_t tbegin;
    pos_t tfinish;
    pos_t kids;
    jtok_pkg::status_t st;
    logic lastr;
  } token_rec_t;

  typedef struct {
    logic [7:0] c;
    logic f;
    bit typed;
    token_rec_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] text_byte = 8'h00;
  logic final_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] token_type;
  pos_t token_number;
  pos_t token_begin;
  pos_t token_finish;
  pos_t child_count;
  logic [2:0] status;
  logic last_result;

  json_tokenizer DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // tokenizer state as predicted
  scan_t scan_st;
  logic [7:0] prev_char;
  pos_t cur_pos;
  pos_t pend_pos;
  pos_t tok_count;
  int open_count;
  bit open_is_array[DEPTH_MAX];
  pos_t open_start[DEPTH_MAX];
  pos_t open_index[DEPTH_MAX];
  pos_t open_kids[DEPTH_MAX];
  bit sticky_err;

  token_rec_t fresh[$];
  token_rec_t token_results[$];
  token_rec_t idle_rec;
  stim_row_t directed[$];
  logic [8:0] text_q[$];

  int fail_count = 0;
  int busy_bytes = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  task automatic note_mismatch(string what, longint got, longint want);
    fail_count++;
    if (fail_count <= 50)
      $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic void clear_tokenizer();
    scan_st = SCAN_IDLE;
    prev_char = jtok_pkg::CH_NUL;
    cur_pos = '0;
    pend_pos = '0;
    tok_count = '0;
    open_count = 0;
    sticky_err = 1'b0;
  endfunction

  function automatic void add_rec(logic [1:0] kind, pos_t num, pos_t b, pos_t fin, pos_t kids,
                                  jtok_pkg::status_t st);
    token_rec_t r;
    r = '{kind, num, b, fin, kids, st, 1'b0};
    fresh.insert(fresh.size(), r);
  endfunction

  function automatic void count_child();
    if (open_count > 0) open_kids[open_count-1] += 1'b1;
  endfunction

  function automatic void emit_leaf(logic [1:0] kind, pos_t fin);
    add_rec(kind, tok_count, pend_pos, fin, '0, jtok_pkg::ST_TOKEN);
    tok_count += 1'b1;
    count_child();
  endfunction

  function automatic void handle_between(logic [7:0] c);
    case (c)
      jtok_pkg::CH_QUOTE: begin
        scan_st = SCAN_STRING;
        pend_pos = cur_pos + 1'b1;
      end
      jtok_pkg::CH_LBRACE, jtok_pkg::CH_LBRACKET: begin
        if (open_count >= DEPTH_MAX) begin
          sticky_err = 1'b1;
          add_rec(jtok_pkg::TT_OBJECT, '0, '0, cur_pos, '0, jtok_pkg::ST_OVERFLOW);
        end else begin
          count_child();
          open_is_array[open_count] = (c == jtok_pkg::CH_LBRACKET);
          open_start[open_count] = cur_pos;
          open_index[open_count] = tok_count;
          open_kids[open_count] = '0;
          open_count++;
          tok_count += 1'b1;
        end
      end
      jtok_pkg::CH_RBRACE, jtok_pkg::CH_RBRACKET: begin
        if (open_count == 0) begin
          sticky_err = 1'b1;
          add_rec(jtok_pkg::TT_OBJECT, '0, '0, cur_pos, '0, jtok_pkg::ST_NO_OPENER);
        end else if (open_is_array[open_count-1] != (c == jtok_pkg::CH_RBRACKET)) begin
          sticky_err = 1'b1;
          add_rec(jtok_pkg::TT_OBJECT, '0, '0, cur_pos, '0, jtok_pkg::ST_MISMATCH);
        end else begin
          open_count--;
          add_rec(open_is_array[open_count] ? jtok_pkg::TT_ARRAY : jtok_pkg::TT_OBJECT,
                  open_index[open_count], open_start[open_count], cur_pos,
                  open_kids[open_count], jtok_pkg::ST_TOKEN);
        end
      end
      jtok_pkg::CH_SPACE, jtok_pkg::CH_TAB, jtok_pkg::CH_CR, jtok_pkg::CH_LF,
      jtok_pkg::CH_COLON, jtok_pkg::CH_COMMA: ;
      default: begin
        scan_st = SCAN_PRIM;
        pend_pos = cur_pos;
      end
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic f);
    bit ends;
    bit esc;
    fresh.delete();
    ends = (c == jtok_pkg::CH_NUL) || f;
    if (sticky_err) begin
      if (ends) clear_tokenizer();
      return;
    end
    if (c != jtok_pkg::CH_NUL) begin
      if (scan_st == SCAN_STRING) begin
        esc = (prev_char == jtok_pkg::CH_BSLASH);
        if (!esc && c == jtok_pkg::CH_QUOTE) begin
          emit_leaf(jtok_pkg::TT_STRING, cur_pos);
          scan_st = SCAN_IDLE;
        end
        prev_char = esc ? jtok_pkg::CH_NUL : c;
      end else if (scan_st == SCAN_PRIM) begin
        if (c == jtok_pkg::CH_SPACE || c == jtok_pkg::CH_TAB || c == jtok_pkg::CH_CR ||
            c == jtok_pkg::CH_LF || c == jtok_pkg::CH_COMMA ||
            c == jtok_pkg::CH_RBRACE || c == jtok_pkg::CH_RBRACKET) begin
          emit_leaf(jtok_pkg::TT_PRIMITIVE, cur_pos);
          scan_st = SCAN_IDLE;
          handle_between(c);
        end
        prev_char = c;
      end else begin
        handle_between(c);
        prev_char = c;
      end
      cur_pos += 1'b1;
    end
    if (ends) begin
      if (!sticky_err) begin
        if (scan_st == SCAN_STRING) emit_leaf(jtok_pkg::TT_STRING, cur_pos);
        else if (scan_st == SCAN_PRIM) emit_leaf(jtok_pkg::TT_PRIMITIVE, cur_pos);
        add_rec(jtok_pkg::TT_OBJECT, tok_count, '0, cur_pos, '0,
                (open_count != 0) ? jtok_pkg::ST_UNCLOSED : jtok_pkg::ST_DONE);
      end
      clear_tokenizer();
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].lastr = 1'b1;
  endfunction

  // text generation
  function automatic void put_char(logic [7:0] c);
    text_q.insert(text_q.size(), {1'b0, c});
  endfunction

  function automatic void add_ws();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: put_char(jtok_pkg::CH_SPACE);
        1: put_char(jtok_pkg::CH_TAB);
        2: put_char(jtok_pkg::CH_CR);
        default: put_char(jtok_pkg::CH_LF);
      endcase
    end
  endfunction

  function automatic void add_string();
    logic [7:0] c;
    int n;
    put_char(jtok_pkg::CH_QUOTE);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          put_char(jtok_pkg::CH_BSLASH);
          put_char(8'($urandom_range(1, 255)));
        end
        1: put_char(8'($urandom_range(128, 255)));
        default: begin
          c = 8'($urandom_range(8'h23, 8'h7E));
          put_char((c == jtok_pkg::CH_BSLASH) ? 8'h61 : c);
        end
      endcase
    end
    put_char(jtok_pkg::CH_QUOTE);
  endfunction

  function automatic void add_prim();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: put_char(8'($urandom_range(8'h30, 8'h39)));
        1: put_char(8'($urandom_range(8'h61, 8'h7A)));
        2: put_char(8'($urandom_range(128, 255)));
        default: put_char((i == 0) ? 8'h2D : jtok_pkg::CH_COLON);
      endcase
    end
  endfunction

  function automatic void add_value(int lvl);
    int n;
    int pick;
    pick = (lvl >= 3) ? $urandom_range(2, 3) : $urandom_range(0, 3);
    add_ws();
    case (pick)
      0: begin
        put_char(jtok_pkg::CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_char(jtok_pkg::CH_COMMA);
          add_ws();
          add_string();
          add_ws();
          put_char(jtok_pkg::CH_COLON);
          add_value(lvl + 1);
        end
        add_ws();
        put_char(jtok_pkg::CH_RBRACE);
      end
      1: begin
        put_char(jtok_pkg::CH_LBRACKET);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_char(jtok_pkg::CH_COMMA);
          add_value(lvl + 1);
        end
        put_char(jtok_pkg::CH_RBRACKET);
      end
      2: add_string();
      default: add_prim();
    endcase
    add_ws();
  endfunction

  function automatic void build_text(bit force_deep);
    text_kind_t kind;
    bit opened[$];
    int n;
    int idx;
    text_q.delete();
    case ($urandom_range(0, 9))
      0: kind = TEXT_DEEP;
      1: kind = TEXT_CUT;
      2: kind = TEXT_BROKEN;
      3: kind = TEXT_NOISE;
      default: kind = TEXT_VALID;
    endcase
    if (force_deep) kind = TEXT_DEEP;
    case (kind)
      TEXT_DEEP: begin
        n = force_deep ? DEPTH_MAX + 1 : $urandom_range(DEPTH_MAX - 3, DEPTH_MAX + 2);
        for (int i = 0; i < n; i++) begin
          opened.insert(opened.size(), 1'($urandom_range(0, 1)));
          put_char(opened[i] ? jtok_pkg::CH_LBRACKET : jtok_pkg::CH_LBRACE);
          if ($urandom_range(0, 2) == 0) begin
            add_prim();
            put_char(jtok_pkg::CH_COMMA);
          end
        end
        for (int i = n - 1; i >= 0; i--)
          put_char(opened[i] ? jtok_pkg::CH_RBRACKET : jtok_pkg::CH_RBRACE);
      end
      TEXT_NOISE: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) put_char(8'($urandom_range(0, 255)));
      end
      default: begin
        add_value(0);
        if ($urandom_range(0, 3) == 0) add_value(0);
        if (kind == TEXT_CUT && text_q.size() > 1)
          text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
        if (kind == TEXT_BROKEN) begin
          idx = $urandom_range(0, text_q.size() - 1);
          case ($urandom_range(0, 4))
            0: text_q[idx] = {1'b0, jtok_pkg::CH_RBRACE};
            1: text_q[idx] = {1'b0, jtok_pkg::CH_RBRACKET};
            2: text_q[idx] = {1'b0, jtok_pkg::CH_LBRACE};
            3: text_q[idx] = {1'b0, jtok_pkg::CH_QUOTE};
            default: text_q[idx] = {1'b0, 8'($urandom_range(1, 255))};
          endcase
        end
      end
    endcase
    case ($urandom_range(0, 2))
      0: text_q.insert(text_q.size(), {1'b0, jtok_pkg::CH_NUL});
      1: text_q.insert(text_q.size(), {1'b1, jtok_pkg::CH_NUL});
      default: text_q[text_q.size()-1][8] = 1'b1;
    endcase
  endfunction

  // the request is sampled at the falling edge and taken at the next rising edge
  task automatic send_byte(logic [7:0] c, logic f, bit typed, token_rec_t want);
    bit took;
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    text_byte <= c;
    final_byte <= f;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      if (!in_stall) begin
        took = 1'b1;
        busy_bytes++;
        tokenize_byte(c, f);
        if (typed) token_results.insert(token_results.size(), want);
        else foreach (fresh[i]) token_results.insert(token_results.size(), fresh[i]);
      end
      @(posedge clk);
    end
  endtask

  function automatic void stim_row(logic [7:0] c, logic f);
    stim_row_t r;
    r.c = c;
    r.f = f;
    r.typed = 1'b0;
    r.want = idle_rec;
    directed.insert(directed.size(), r);
  endfunction

  task automatic check_token();
    token_rec_t want;
    if (token_results.size() == 0) begin
      note_mismatch("result with nothing pending, status", status, 0);
      return;
    end
    want = token_results.pop_front();
    if (token_type !== want.kind) note_mismatch("token_type", token_type, want.kind);
    if (token_number !== want.num) note_mismatch("token_number", token_number, want.num);
    if (token_begin !== want.tbegin) note_mismatch("token_begin", token_begin, want.tbegin);
    if (token_finish !== want.tfinish) note_mismatch("token_finish", token_finish, want.tfinish);
    if (child_count !== want.kids) note_mismatch("child_count", child_count, want.kids);
    if (status !== want.st) note_mismatch("status", status, want.st);
    if (last_result !== want.lastr) note_mismatch("last_result", last_result, want.lastr);
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) check_token();
  end

  initial begin : receiver
    stall_mode_t mode;
    int mode_left;
    int hold_left;
    bit hold_taken;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    bit paused;
    bit first_text;
    paused = 1'b0;
    first_text = 1'b1;
    clear_tokenizer();

    stim_row(jtok_pkg::CH_NUL, 1'b0);
    directed[$].typed = 1'b1;
    directed[$].want = '{jtok_pkg::TT_OBJECT, 24'd0, 24'd0, 24'd0, 24'd0,
                         jtok_pkg::ST_DONE, 1'b1};
    stim_row(jtok_pkg::CH_RBRACE, 1'b0);
    directed[$].typed = 1'b1;
    directed[$].want = '{jtok_pkg::TT_OBJECT, 24'd0, 24'd0, 24'd0, 24'd0,
                         jtok_pkg::ST_NO_OPENER, 1'b1};
    stim_row(8'hFF, 1'b0);
    stim_row(jtok_pkg::CH_NUL, 1'b0);
    stim_row(jtok_pkg::CH_LBRACKET, 1'b0);
    stim_row(jtok_pkg::CH_QUOTE, 1'b0);
    stim_row(jtok_pkg::CH_BSLASH, 1'b0);
    stim_row(jtok_pkg::CH_BSLASH, 1'b0);
    stim_row(jtok_pkg::CH_QUOTE, 1'b0);
    stim_row(jtok_pkg::CH_COMMA, 1'b0);
    stim_row(jtok_pkg::CH_QUOTE, 1'b0);
    stim_row(jtok_pkg::CH_BSLASH, 1'b0);
    stim_row(jtok_pkg::CH_QUOTE, 1'b0);
    stim_row(jtok_pkg::CH_QUOTE, 1'b0);
    stim_row(8'hFF, 1'b0);
    stim_row(jtok_pkg::CH_RBRACE, 1'b0);
    stim_row(jtok_pkg::CH_NUL, 1'b0);
    stim_row(jtok_pkg::CH_LBRACE, 1'b0);
    stim_row(8'h61, 1'b1);
    stim_row(jtok_pkg::CH_NUL, 1'b1);
    directed[$].typed = 1'b1;
    directed[$].want = '{jtok_pkg::TT_OBJECT, 24'd0, 24'd0, 24'd0, 24'd0,
                         jtok_pkg::ST_DONE, 1'b1};
    stim_row(8'h37, 1'b0);
    stim_row(jtok_pkg::CH_SPACE, 1'b0);
    stim_row(jtok_pkg::CH_RBRACKET, 1'b0);
    directed[$].typed = 1'b1;
    directed[$].want = '{jtok_pkg::TT_OBJECT, 24'd0, 24'd0, 24'd2, 24'd0,
                         jtok_pkg::ST_NO_OPENER, 1'b1};
    stim_row(jtok_pkg::CH_NUL, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i].c, directed[i].f, directed[i].typed,
                                    directed[i].want);
    in_valid <= 1'b0;
    wait (token_results.size() == 0);
    @(posedge clk);

    while (busy_bytes < BYTE_TARGET) begin
      build_text(first_text);
      first_text = 1'b0;
      foreach (text_q[i]) send_byte(text_q[i][7:0], text_q[i][8], 1'b0, idle_rec);
      if (!hold_req && busy_bytes >= 150) hold_req = 1'b1;
      if (!paused && busy_bytes >= 300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        wait (token_results.size() == 0);
        @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    wait (token_results.size() == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
